[rtl/core/dtmf_pkg.sv]
// Shared types and constants of the DTMF Goertzel detector.
// Used by every module under rtl/core; depends on nothing else.
package dtmf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int STATE_W    = 48;
	localparam int COEF_W     = 16;
	localparam int COEF_FRAC  = 14;
	localparam int NFILT      = 8;
	localparam int NREG       = 8;
	localparam int FIDX_W     = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int MUL_A_W    = COEF_W + STATE_W;
	localparam int PROD_W     = 2 * STATE_W + COEF_W;
	localparam int MAG_W      = 51;
	localparam int RAD_W      = 2 * MAG_W;
	localparam int SUM_W      = MAG_W + 2;
	localparam int RATIO_W    = 17;
	localparam int CONF_W     = 16;
	localparam int DIVD_W     = MAG_W + CONF_W;
	localparam logic [CONF_W-1:0] CONF_THRESHOLD = 16'd26214;

	typedef logic signed [STATE_W-1:0] state_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic [MAG_W-1:0]          mag_t;

	localparam coef_t COEF_RESET [NREG] = '{
		16'sd27980, 16'sd26955, 16'sd25700, 16'sd24219,
		16'sd19073, 16'sd16302, 16'sd13085, 16'sd9316
	};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       block_end;
	} item_t;

	typedef struct packed {
		logic [3:0]        digit_code;
		logic              digit_valid;
		logic [1:0]        row_index;
		logic [1:0]        col_index;
		logic [CONF_W-1:0] confidence;
	} result_t;

	// Classified sample: last is set for block_end and for an overlong block
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} q_item_t;

	typedef struct packed {
		state_t prev;
		state_t prev2;
		coef_t  coef;
	} filt_view_t;

endpackage

[rtl/core/dtmf_front.sv]
// Front end: takes samples, marks block ends (explicit or overlong) and
// queues them two deep for the filter bank. Depends on dtmf_pkg.
module dtmf_front import dtmf_pkg::*; #(
	parameter int MAX_BLOCK = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    q_valid,
	output q_item_t q_data,
	input  logic    q_pop
);

	localparam int CNT_W = $clog2(MAX_BLOCK);

	q_item_t          mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       fill_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept, last;

	assign busy    = (fill_q == 2'd2);
	assign accept  = start & ~busy;
	assign last    = item.block_end | (cnt_q == CNT_W'(MAX_BLOCK - 1));
	assign q_valid = (fill_q != 2'd0);
	assign q_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= ~wr_ptr_q;
				cnt_q    <= last ? '0 : cnt_q + 1'b1;
			end
			if (q_pop)
				rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + 2'(accept) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			mem_q[wr_ptr_q] <= '{sample: item.sample, last: last};
	end

endmodule

[rtl/core/dtmf_filt.sv]
// Filter bank: coefficient registers, eight Goertzel states and one shared
// 16x48 multiplier stepping through the filters. Depends on dtmf_pkg.
module dtmf_filt import dtmf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [COEF_W-1:0]    cfg_wdata,
	input  logic                 q_valid,
	input  q_item_t              q_data,
	output logic                 q_pop,
	output logic                 fin_start,
	input  logic [FIDX_W-1:0]    fin_idx,
	input  logic                 fin_done,
	output filt_view_t           view
);

	localparam int ACC2_W = MUL_A_W - COEF_FRAC + 2;

	typedef enum logic [1:0] {F_IDLE, F_RUN, F_DRAIN, F_FIN} filt_state_t;

	filt_state_t                state_q;
	logic [FIDX_W-1:0]          k_q, k_s1, rd_idx;
	logic signed [SAMPLE_W-1:0] x_q, x_s1;
	logic                       last_q, vld_s1, fin_start_q;
	coef_t                      coef_q [NREG];
	state_t                     prev_q [NFILT];
	state_t                     prev2_q [NFILT];
	state_t                     prev_s1, prev2_s1, sat;
	logic signed [MUL_A_W-1:0]  coef_x, prev_x, prod_s1;
	logic signed [ACC2_W-1:0]   sum;
	logic [ACC2_W-STATE_W:0]    hi;

	assign rd_idx     = (state_q == F_FIN) ? fin_idx : k_q;
	assign view.prev  = prev_q[rd_idx];
	assign view.prev2 = prev2_q[rd_idx];
	assign view.coef  = coef_q[rd_idx];
	assign fin_start  = fin_start_q;

	assign q_pop = q_valid & ((state_q == F_IDLE) |
		((state_q == F_RUN) & (k_q == FIDX_W'(NFILT - 1)) & ~last_q));

	assign coef_x = MUL_A_W'(view.coef);
	assign prev_x = MUL_A_W'(view.prev);

	// s = x + floor(c*prev / 2^F) - prev2, saturated to the state width
	assign sum = ACC2_W'(prod_s1 >>> COEF_FRAC) + ACC2_W'(x_s1) - ACC2_W'(prev2_s1);
	assign hi  = sum[ACC2_W-1:STATE_W-1];
	always_comb begin
		if ((&hi) | ~(|hi))
			sat = sum[STATE_W-1:0];
		else
			sat = hi[ACC2_W-STATE_W] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			k_q         <= '0;
			last_q      <= 1'b0;
			vld_s1      <= 1'b0;
			fin_start_q <= 1'b0;
		end else begin
			vld_s1      <= (state_q == F_RUN);
			fin_start_q <= (state_q == F_DRAIN);
			unique case (state_q)
				F_IDLE: begin
					if (q_valid) begin
						last_q  <= q_data.last;
						k_q     <= '0;
						state_q <= F_RUN;
					end
				end
				F_RUN: begin
					k_q <= k_q + 1'b1;
					if (k_q == FIDX_W'(NFILT - 1)) begin
						if (last_q)
							state_q <= F_DRAIN;
						else if (q_valid)
							last_q <= q_data.last;
						else
							state_q <= F_IDLE;
					end
				end
				F_DRAIN: state_q <= F_FIN;
				F_FIN: begin
					if (fin_done)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			x_q <= q_data.sample;
		prod_s1  <= coef_x * prev_x;
		prev_s1  <= view.prev;
		prev2_s1 <= view.prev2;
		x_s1     <= x_q;
		k_s1     <= k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NFILT; i++) begin
				prev_q[i]  <= '0;
				prev2_q[i] <= '0;
			end
		end else if ((state_q == F_FIN) && fin_done) begin
			for (int i = 0; i < NFILT; i++) begin
				prev_q[i]  <= '0;
				prev2_q[i] <= '0;
			end
		end else if (vld_s1) begin
			prev2_q[k_s1] <= prev_s1;
			prev_q[k_s1]  <= sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREG; i++)
				coef_q[i] <= COEF_RESET[i];
		end else if (cfg_we && (cfg_idx < CFG_IDX_W'(NREG))) begin
			coef_q[cfg_idx[FIDX_W-1:0]] <= cfg_wdata;
		end
	end

endmodule

[rtl/core/dtmf_fin.sv]
// Block-end engine: power, square root, row/column pick, ratios and
// confidence; power, root and ratios on bit-serial units. Depends on dtmf_pkg.
module dtmf_fin import dtmf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  filt_view_t        view,
	output logic [FIDX_W-1:0] idx,
	output logic              done,
	output logic              result_valid,
	output result_t           result
);

	typedef enum logic [3:0] {
		S_IDLE, S_LD, S_MUL, S_COL, S_PWR, S_SQ, S_ACC, S_DIV, S_CONF, S_OUT
	} fin_state_t;

	fin_state_t                state_q;
	logic [FIDX_W-1:0]         k_q;
	logic [1:0]                step_q;
	logic [6:0]                cnt_q;
	state_t                    r1_q, r2_q;
	coef_t                     c_q;
	logic [PROD_W-1:0]         ma_q, acc_q;
	logic [STATE_W-1:0]        mb_q;
	logic                      neg_q;
	logic signed [PROD_W-1:0]  prod, sq_q, pw_q;
	logic [RAD_W-1:0]          rad_q;
	logic [MAG_W+2:0]          rem_q, sq_rem, trial;
	mag_t                      root_q, brm_q, bcm_q;
	logic [1:0]                best_row_q, best_col_q;
	logic [SUM_W-1:0]          row_sum_q, col_sum_q, dr_q;
	logic [DIVD_W-1:0]         dn_q;
	logic [SUM_W:0]            drem_q, d_rem;
	logic                      d_ge, div_col_q, valid_q;
	logic [RATIO_W-1:0]        qt_q, q_next, rq_q;
	logic [2*RATIO_W-1:0]      cp_q;
	logic [RATIO_W:0]          conf_sh;
	logic [CONF_W-1:0]         conf;
	result_t                   result_q;

	function automatic logic [MUL_A_W-1:0] abs_a(input logic signed [MUL_A_W-1:0] a);
		return a[MUL_A_W-1] ? -a : a;
	endfunction

	function automatic logic [STATE_W-1:0] abs_b(input state_t b);
		return b[STATE_W-1] ? -b : b;
	endfunction

	assign idx          = k_q;
	assign done         = valid_q;
	assign result_valid = valid_q;
	assign result       = result_q;

	assign prod   = neg_q ? -acc_q : acc_q;
	assign sq_rem = {rem_q[MAG_W:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign d_rem  = {drem_q[SUM_W-1:0], dn_q[DIVD_W-1]};
	assign d_ge   = d_rem >= {1'b0, dr_q};
	assign q_next = {qt_q[RATIO_W-2:0], d_ge};

	assign conf_sh = cp_q[2*RATIO_W-1:CONF_W];
	assign conf    = (|conf_sh[RATIO_W:CONF_W]) ? {CONF_W{1'b1}} : conf_sh[CONF_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
			k_q     <= '0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					k_q       <= '0;
					row_sum_q <= '0;
					col_sum_q <= '0;
					if (start)
						state_q <= S_LD;
				end
				S_LD: begin
					r1_q   <= view.prev;
					r2_q   <= view.prev2;
					c_q    <= view.coef;
					ma_q   <= PROD_W'(abs_a(MUL_A_W'(view.prev)));
					mb_q   <= abs_b(view.prev);
					neg_q  <= 1'b0;
					acc_q  <= '0;
					cnt_q  <= '0;
					step_q <= 2'd0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mb_q[0])
						acc_q <= acc_q + ma_q;
					ma_q  <= ma_q << 1;
					mb_q  <= mb_q >> 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'(STATE_W - 1))
						state_q <= S_COL;
				end
				S_COL: begin
					// collect the product, then set up the next one or, after the last, form the power
					acc_q  <= '0;
					cnt_q  <= '0;
					step_q <= step_q + 1'b1;
					state_q <= S_MUL;
					case (step_q)
						2'd0: begin
							sq_q  <= prod;
							ma_q  <= PROD_W'(abs_a(MUL_A_W'(r2_q)));
							mb_q  <= abs_b(r2_q);
							neg_q <= 1'b0;
						end
						2'd1: begin
							sq_q  <= sq_q + prod;
							ma_q  <= PROD_W'(abs_a(MUL_A_W'(c_q)));
							mb_q  <= abs_b(r1_q);
							neg_q <= c_q[COEF_W-1] ^ r1_q[STATE_W-1];
						end
						2'd2: begin
							ma_q  <= PROD_W'(abs_a(prod[MUL_A_W-1:0]));
							mb_q  <= abs_b(r2_q);
							neg_q <= prod[MUL_A_W-1] ^ r2_q[STATE_W-1];
						end
						default: begin
							pw_q    <= (sq_q <<< COEF_FRAC) - prod;
							state_q <= S_PWR;
						end
					endcase
				end
				S_PWR: begin
					rad_q   <= pw_q[PROD_W-1] ? '0 : RAD_W'(pw_q[PROD_W-1:COEF_FRAC]);
					rem_q   <= '0;
					root_q  <= '0;
					cnt_q   <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					// one root bit per cycle, two radicand bits in
					rad_q <= rad_q << 2;
					if (sq_rem >= trial) begin
						rem_q  <= sq_rem - trial;
						root_q <= {root_q[MAG_W-2:0], 1'b1};
					end else begin
						rem_q  <= sq_rem;
						root_q <= {root_q[MAG_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'(MAG_W - 1))
						state_q <= S_ACC;
				end
				S_ACC: begin
					if (!k_q[2]) begin
						if ((k_q[1:0] == 2'd0) || (root_q > brm_q)) begin
							brm_q      <= root_q;
							best_row_q <= k_q[1:0];
						end
						row_sum_q <= row_sum_q + SUM_W'(root_q);
					end else begin
						if ((k_q[1:0] == 2'd0) || (root_q > bcm_q)) begin
							bcm_q      <= root_q;
							best_col_q <= k_q[1:0];
						end
						col_sum_q <= col_sum_q + SUM_W'(root_q);
					end
					if (k_q == FIDX_W'(NFILT - 1)) begin
						dn_q      <= {brm_q, {CONF_W{1'b0}}};
						dr_q      <= row_sum_q;
						div_col_q <= 1'b0;
						state_q   <= S_DIV;
					end else begin
						state_q <= S_LD;
					end
					k_q   <= k_q + 1'b1;
					drem_q <= '0;
					cnt_q  <= '0;
				end
				S_DIV: begin
					dn_q  <= dn_q << 1;
					qt_q  <= q_next;
					drem_q <= d_ge ? d_rem - {1'b0, dr_q} : d_rem;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'(DIVD_W - 1)) begin
						cnt_q  <= '0;
						drem_q <= '0;
						if (!div_col_q) begin
							rq_q      <= (dr_q == '0) ? '0 : q_next;
							dn_q      <= {bcm_q, {CONF_W{1'b0}}};
							dr_q      <= col_sum_q;
							div_col_q <= 1'b1;
						end else begin
							cp_q    <= rq_q * ((dr_q == '0) ? '0 : q_next);
							state_q <= S_CONF;
						end
					end
				end
				S_CONF: begin
					result_q.digit_code  <= {best_row_q, best_col_q};
					result_q.digit_valid <= conf > CONF_THRESHOLD;
					result_q.row_index   <= best_row_q;
					result_q.col_index   <= best_col_q;
					result_q.confidence  <= conf;
					state_q <= S_OUT;
				end
				S_OUT: begin
					valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_single_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe longer than one cycle");
	a_code_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.digit_code == {result.row_index, result.col_index})
		else $error("digit code does not match indices");
	a_valid_thresh: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.digit_valid == (result.confidence > CONF_THRESHOLD))
		else $error("digit valid inconsistent with confidence");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == S_IDLE) else $error("block end while engine busy");
`endif

endmodule

[rtl/core/dtmf_goertzel_detector_core.sv]
// Top level of the DTMF Goertzel detector: front end, filter bank and
// block-end engine. Depends on dtmf_pkg, dtmf_front, dtmf_filt, dtmf_fin.
//
// A sample is taken when start is high and busy is low; each sample passes
// the filters in turn through the single shared 16x48 multiplier, and
// a two-entry queue lets samples be accepted while the bank works. On the
// last sample of a block (block_end, or MAX_BLOCK samples) the block-end
// engine computes, per filter, four serial products and a serial square
// root, then two serial divisions. Samples queue while it runs and busy is
// raised once the queue is full. The result is shown for one cycle with
// result_valid and cannot be stalled.
module dtmf_goertzel_detector_core import dtmf_pkg::*; #(
	parameter int MAX_BLOCK = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  item_t                item,
	output logic                 result_valid,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [COEF_W-1:0]    cfg_wdata
);

	logic              q_valid, q_pop, fin_start, fin_done;
	q_item_t           q_data;
	logic [FIDX_W-1:0] fin_idx;
	filt_view_t        view;

	dtmf_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop)
	);

	dtmf_filt u_filt (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.fin_start (fin_start),
		.fin_idx   (fin_idx),
		.fin_done  (fin_done),
		.view      (view)
	);

	dtmf_fin u_fin (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (fin_start),
		.view         (view),
		.idx          (fin_idx),
		.done         (fin_done),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

[bench/dtmf_goertzel_detector_core_test.sv]
// Self-checking bench for the DTMF Goertzel detector core: drives sample blocks,
// predicts each block-end digit in a scoreboard class and compares the results.
// Depends on dtmf_pkg and dtmf_goertzel_detector_core.
module dtmf_goertzel_detector_core_test;
	import dtmf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_BLK = 256;
	localparam int CYCLE_LIMIT = 20000000;

	typedef logic signed [127:0] wide_t;
	typedef logic [127:0] uwide_t;

	class digit_scoreboard;
		coef_t  coef [NREG];
		state_t prev [NFILT];
		state_t prev2 [NFILT];
		int     blk_len;
		result_t pending_digits [$];
		int     errors;
		int     digits_seen;
		int     valid_seen;

		function void reset_state();
			for (int k = 0; k < NREG; k++) coef[k] = COEF_RESET[k];
			clear_filters();
			errors = 0;
			digits_seen = 0;
			valid_seen = 0;
		endfunction

		function void clear_filters();
			for (int k = 0; k < NFILT; k++) begin
				prev[k] = '0;
				prev2[k] = '0;
			end
			blk_len = 0;
		endfunction

		function void write_reg(int idx, logic [COEF_W-1:0] val);
			if (idx < NREG) coef[idx] = coef_t'(val);
		endfunction

		function state_t next_state(coef_t c, state_t p, state_t p2, logic signed [15:0] x);
			wide_t cw, pw, p2w, xw, t, hi, lo;
			cw = c;
			pw = p;
			p2w = p2;
			xw = x;
			hi = (wide_t'(1) <<< (STATE_W - 1)) - 1;
			lo = -hi - 1;
			t = ((cw * pw) >>> COEF_FRAC) + xw - p2w;
			if (t > hi) return state_t'(hi);
			if (t < lo) return state_t'(lo);
			return state_t'(t);
		endfunction

		function mag_t tone_magnitude(state_t s1, state_t s2, coef_t c);
			wide_t r1, r2, cw, pw;
			uwide_t pu, cand, root;
			r1 = s1;
			r2 = s2;
			cw = c;
			pw = ((r1 * r1 + r2 * r2) <<< COEF_FRAC) - cw * r1 * r2;
			if (pw < 0) return '0;
			pu = uwide_t'(pw >>> COEF_FRAC);
			root = '0;
			for (int b = MAG_W - 1; b >= 0; b--) begin
				cand = root | (uwide_t'(1) << b);
				if (cand * cand <= pu) root = cand;
			end
			return mag_t'(root);
		endfunction

		function logic [16:0] share_q16(uwide_t a, uwide_t b);
			uwide_t q;
			if (b == 0) return '0;
			q = (a << 16) / b;
			return (q > 65536) ? 17'd65536 : 17'(q);
		endfunction

		function void note_sample(item_t it);
			state_t ns;
			mag_t mag [NFILT];
			uwide_t row_sum, col_sum, prodq;
			logic [16:0] rq, cq;
			int br, bc;
			result_t r;
			for (int k = 0; k < NFILT; k++) begin
				ns = next_state(coef[k], prev[k], prev2[k], it.sample);
				prev2[k] = prev[k];
				prev[k] = ns;
			end
			blk_len++;
			if (!it.block_end && blk_len < MAX_BLK) return;
			row_sum = 0;
			col_sum = 0;
			br = 0;
			bc = 0;
			for (int k = 0; k < NFILT; k++) mag[k] = tone_magnitude(prev[k], prev2[k], coef[k]);
			for (int k = 0; k < 4; k++) begin
				if (mag[k] > mag[br]) br = k;
				if (mag[4+k] > mag[4+bc]) bc = k;
				row_sum += mag[k];
				col_sum += mag[4+k];
			end
			rq = share_q16(mag[br], row_sum);
			cq = share_q16(mag[4+bc], col_sum);
			prodq = (uwide_t'(rq) * cq) >> 16;
			if (prodq > 65535) prodq = 65535;
			r.digit_code = 4'(br * 4 + bc);
			r.confidence = 16'(prodq);
			r.digit_valid = (r.confidence > CONF_THRESHOLD);
			r.row_index = 2'(br);
			r.col_index = 2'(bc);
			pending_digits.push_back(r);
			clear_filters();
		endfunction

		function void check_digit(result_t got);
			result_t exp_r;
			if (pending_digits.size() == 0) begin
				$error("digit result with nothing expected: %h", got);
				errors++;
				return;
			end
			exp_r = pending_digits.pop_front();
			digits_seen++;
			if (got.digit_valid) valid_seen++;
			if (got.digit_code !== exp_r.digit_code) begin
				$error("digit_code expected %0d got %0d", exp_r.digit_code, got.digit_code);
				errors++;
			end
			if (got.digit_valid !== exp_r.digit_valid) begin
				$error("digit_valid expected %0d got %0d", exp_r.digit_valid, got.digit_valid);
				errors++;
			end
			if (got.row_index !== exp_r.row_index) begin
				$error("row_index expected %0d got %0d", exp_r.row_index, got.row_index);
				errors++;
			end
			if (got.col_index !== exp_r.col_index) begin
				$error("col_index expected %0d got %0d", exp_r.col_index, got.col_index);
				errors++;
			end
			if (got.confidence !== exp_r.confidence) begin
				$error("confidence expected %0d got %0d", exp_r.confidence, got.confidence);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t item = '0;
	logic result_valid;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [COEF_W-1:0] cfg_wdata = '0;

	digit_scoreboard sb = new();
	int cycles = 0;
	int samples_sent = 0;
	int blocks_sent = 0;
	real row_hz [4] = '{697.0, 770.0, 852.0, 941.0};
	real col_hz [4] = '{1209.0, 1336.0, 1477.0, 1633.0};

	dtmf_goertzel_detector_core #(.MAX_BLOCK(MAX_BLK)) i_dut (
		.clk, .arst_n, .start, .busy, .item, .result_valid, .result,
		.cfg_we, .cfg_idx, .cfg_wdata
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check_digit(result);
	end

	function int pick_gap(bit no_idle);
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 6);
		return $urandom_range(20, 300);
	endfunction

	// Hold start high across back-to-back transactions; drop it only for a gap.
	task automatic send_sample(logic signed [15:0] s, logic last, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= '{sample: s, block_end: last};
		do @(posedge clk); while (busy);
		sb.note_sample('{sample: s, block_end: last});
		samples_sent++;
		if (last) blocks_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending_digits.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_coefs(coef_t v [NREG]);
		for (int k = 0; k < NREG; k++) begin
			cfg_we <= 1'b1;
			cfg_idx <= CFG_IDX_W'(k);
			cfg_wdata <= v[k];
			@(posedge clk);
			sb.write_reg(k, v[k]);
		end
		// out-of-range index: must be ignored
		cfg_we <= 1'b1;
		cfg_idx <= CFG_IDX_W'($urandom_range(NREG, 15));
		cfg_wdata <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_block();
		int kind, len, rsel, csel;
		real amp_r, amp_c, v;
		bit no_idle;
		logic signed [15:0] s;
		kind = $urandom_range(0, 99);
		no_idle = ($urandom_range(0, 3) == 0);
		rsel = $urandom_range(0, 3);
		csel = $urandom_range(0, 3);
		amp_r = $urandom_range(0, 16000);
		amp_c = $urandom_range(0, 16000);
		if (kind < 60) len = $urandom_range(16, 60);
		else if (kind < 88) len = $urandom_range(1, 12);
		else if (kind < 96) len = $urandom_range(2, 20);
		else len = MAX_BLK + $urandom_range(0, 5);
		for (int n = 0; n < len; n++) begin
			if (kind < 60) begin
				v = amp_r * $sin(6.283185307 * row_hz[rsel] * n / 8000.0) +
				    amp_c * $sin(6.283185307 * col_hz[csel] * n / 8000.0);
				s = 16'($rtoi(v) + $urandom_range(0, 64) - 32);
			end else if (kind < 96 && kind >= 88) begin
				s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			end else begin
				s = 16'($urandom);
			end
			// an overlong block closes on its own at MAX_BLK samples
			send_sample(s, (len <= MAX_BLK) && (n == len - 1), pick_gap(no_idle));
		end
	endtask

	initial begin
		coef_t set_v [NREG];
		sb.reset_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero energy, single extremes, alternating extremes, a run of one extreme
		for (int n = 0; n < 3; n++) send_sample(16'sd0, n == 2, 0);
		send_sample(16'sh7fff, 1'b1, 0);
		send_sample(16'sh8000, 1'b1, 2);
		for (int n = 0; n < 8; n++) send_sample(n[0] ? 16'sh8000 : 16'sh7fff, n == 7, 0);
		for (int n = 0; n < 6; n++) send_sample(16'sh7fff, n == 5, 1);
		drain();

		for (int ph = 0; samples_sent < 950; ph++) begin
			case (ph % 6)
				0: for (int k = 0; k < NREG; k++) set_v[k] = COEF_RESET[k];
				1: for (int k = 0; k < NREG; k++) set_v[k] = 16'sh7fff;
				2: for (int k = 0; k < NREG; k++) set_v[k] = 16'sh8000;
				3: for (int k = 0; k < NREG; k++) set_v[k] = '0;
				default: for (int k = 0; k < NREG; k++) set_v[k] = coef_t'($urandom);
			endcase
			write_coefs(set_v);
			for (int b = 0; b < ((ph % 6 == 0) ? 10 : 4); b++) random_block();
			drain();
		end

		repeat (3000) @(posedge clk);
		if (sb.pending_digits.size() != 0) begin
			$error("%0d digit results never arrived", sb.pending_digits.size());
			sb.errors++;
		end
		$display("Ran %0d samples in %0d blocks over several coefficient sets;",
			samples_sent, blocks_sent);
		$display("checked %0d digit results, %0d of them valid digits.",
			sb.digits_seen, sb.valid_seen);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
